### rtl/constant_pool_entry_parser_unit_assert.svh
// Assertion macros for the constant pool entry parser.
// Included by constant_pool_entry_parser_unit.sv; no other dependencies.
`ifndef CONSTANT_POOL_ENTRY_PARSER_UNIT_ASSERT_SVH
`define CONSTANT_POOL_ENTRY_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset
`define CPEP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("constant pool parser: implication check failed");

// Next-cycle implication, checked outside reset
`define CPEP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("constant pool parser: next-cycle check failed");

`else

`define CPEP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CPEP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/cpep_pkg.sv
// Package for the constant pool entry parser: tag codes, parse phases,
// result slot codes and the per-tag field layout. No dependencies.
`timescale 1ns / 1ps

package cpep_pkg;

  // Constant pool tag codes
  localparam logic [7:0] TAG_UTF8        = 8'd1;
  localparam logic [7:0] TAG_INTEGER     = 8'd3;
  localparam logic [7:0] TAG_FLOAT       = 8'd4;
  localparam logic [7:0] TAG_LONG        = 8'd5;
  localparam logic [7:0] TAG_DOUBLE      = 8'd6;
  localparam logic [7:0] TAG_CLASS       = 8'd7;
  localparam logic [7:0] TAG_STRING      = 8'd8;
  localparam logic [7:0] TAG_FIELDREF    = 8'd9;
  localparam logic [7:0] TAG_METHODREF   = 8'd10;
  localparam logic [7:0] TAG_IMETHODREF  = 8'd11;
  localparam logic [7:0] TAG_NAMEANDTYPE = 8'd12;
  localparam logic [7:0] TAG_METHODHNDL  = 8'd15;
  localparam logic [7:0] TAG_METHODTYPE  = 8'd16;
  localparam logic [7:0] TAG_DYNAMIC     = 8'd17;
  localparam logic [7:0] TAG_INVOKEDYN   = 8'd18;
  localparam logic [7:0] TAG_MODULE      = 8'd19;
  localparam logic [7:0] TAG_PACKAGE     = 8'd20;

  // Result slot codes
  localparam logic [1:0] SLOT_FIRST  = 2'd0;
  localparam logic [1:0] SLOT_SECOND = 2'd1;
  localparam logic [1:0] SLOT_BODY   = 2'd2;

  // Parse phase
  typedef enum logic [1:0] {
    PH_TAG   = 2'd0,
    PH_FIELD = 2'd1,
    PH_BODY  = 2'd2
  } phase_t;

  // Byte size of field k of an entry; zero means no such field
  function automatic logic [2:0] field_size(input logic [7:0] tag, input logic [1:0] k);
    logic [2:0] sz;
    sz = 3'd0;
    unique case (tag)
      TAG_UTF8:                       sz = (k == 2'd0) ? 3'd2 : 3'd0;
      TAG_INTEGER, TAG_FLOAT:         sz = (k == 2'd0) ? 3'd4 : 3'd0;
      TAG_LONG, TAG_DOUBLE:           sz = (k <= 2'd1) ? 3'd4 : 3'd0;
      TAG_CLASS, TAG_STRING, TAG_METHODTYPE, TAG_MODULE, TAG_PACKAGE:
                                      sz = (k == 2'd0) ? 3'd2 : 3'd0;
      TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF, TAG_NAMEANDTYPE,
      TAG_DYNAMIC, TAG_INVOKEDYN:     sz = (k <= 2'd1) ? 3'd2 : 3'd0;
      TAG_METHODHNDL:                 sz = (k == 2'd0) ? 3'd1 :
                                           ((k == 2'd1) ? 3'd2 : 3'd0);
      default:                        sz = 3'd0;
    endcase
    return sz;
  endfunction

  // Tag recognition; the newer tags depend on the enable bit
  function automatic logic tag_known(input logic [7:0] tag, input logic newer_en);
    logic known;
    if (tag == TAG_DYNAMIC || tag == TAG_MODULE || tag == TAG_PACKAGE) begin
      known = newer_en;
    end else begin
      known = (field_size(tag, 2'd0) != 3'd0);
    end
    return known;
  endfunction

endpackage

### rtl/constant_pool_entry_parser_unit.sv
// Constant pool entry parser: splits a class-file byte stream into entries.
// Depends on cpep_pkg.sv and constant_pool_entry_parser_unit_assert.svh.
//
//   channel  dir  handshake           payload
//   in_      in   in_valid/in_stall   in_stream_byte
//   out_     out  out_valid/out_stall entry_tag, field_slot, field_value,
//                                     tag_known, takes_two_slots, last_of_entry
//   cfg_     in   cfg_wr_en           cfg_wr_data (newer_tags_enabled)
//
// One byte per cycle unless stalled; the result is out the cycle after its last byte.
// The parse state and the single output register set the rate: a byte is taken
// whenever the output register is empty or being drained in the same cycle.
// Synchronous active-low reset returns to the tag phase with newer tags enabled.
// in_stall is high only while a result waits and out_stall is high.
`timescale 1ns / 1ps

module constant_pool_entry_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // byte stream
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_entry_tag,
  output logic [1:0]  out_field_slot,
  output logic [31:0] out_field_value,
  output logic        out_tag_known,
  output logic        out_takes_two_slots,
  output logic        out_last_of_entry
);

`include "constant_pool_entry_parser_unit_assert.svh"

  // Parse state
  cpep_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic        fnum_r, fnum_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        newer_en_r;

  // Output register
  logic        out_valid_r;
  logic [7:0]  o_tag_r, o_tag_nxt;
  logic [1:0]  o_slot_r, o_slot_nxt;
  logic [31:0] o_value_r, o_value_nxt;
  logic        o_known_r, o_known_nxt;
  logic        o_two_r, o_two_nxt;
  logic        o_last_r, o_last_nxt;
  logic        emit;

  // Working values
  logic        in_accept;
  logic [31:0] acc_shift;
  logic [15:0] rem_dec;
  logic [15:0] utf_len;
  logic [2:0]  next_size;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign acc_shift = {acc_r[23:0], in_stream_byte};
  assign rem_dec   = rem_r - 16'd1;
  assign utf_len   = acc_shift[15:0];
  assign next_size = cpep_pkg::field_size(tag_r, {1'b0, fnum_r} + 2'd1);

  // Next state and result for the incoming byte
  always_comb begin
    phase_nxt   = phase_r;
    tag_nxt     = tag_r;
    fnum_nxt    = fnum_r;
    rem_nxt     = rem_r;
    acc_nxt     = acc_r;
    emit        = 1'b0;
    o_tag_nxt   = tag_r;
    o_slot_nxt  = cpep_pkg::SLOT_FIRST;
    o_value_nxt = 32'd0;
    o_known_nxt = 1'b1;
    o_last_nxt  = 1'b0;
    unique case (phase_r)
      cpep_pkg::PH_FIELD: begin
        acc_nxt = acc_shift;
        rem_nxt = rem_dec;
        if (rem_dec == 16'd0) begin
          emit = 1'b1;
          if (tag_r == cpep_pkg::TAG_UTF8) begin
            // length field: go to body unless the string is empty
            o_value_nxt = {16'd0, utf_len};
            o_last_nxt  = (utf_len == 16'd0);
            rem_nxt     = utf_len;
            phase_nxt   = (utf_len == 16'd0) ? cpep_pkg::PH_TAG : cpep_pkg::PH_BODY;
          end else begin
            o_slot_nxt  = {1'b0, fnum_r};
            o_value_nxt = acc_shift;
            o_last_nxt  = (next_size == 3'd0);
            if (next_size == 3'd0) begin
              phase_nxt = cpep_pkg::PH_TAG;
            end else begin
              fnum_nxt = 1'b1;
              rem_nxt  = {13'd0, next_size};
              acc_nxt  = 32'd0;
            end
          end
        end
      end
      cpep_pkg::PH_BODY: begin
        rem_nxt     = rem_dec;
        emit        = 1'b1;
        o_slot_nxt  = cpep_pkg::SLOT_BODY;
        o_value_nxt = {24'd0, in_stream_byte};
        o_last_nxt  = (rem_dec == 16'd0);
        if (rem_dec == 16'd0) begin
          phase_nxt = cpep_pkg::PH_TAG;
        end
      end
      default: begin
        // tag byte
        phase_nxt = cpep_pkg::PH_TAG;
        if (!cpep_pkg::tag_known(in_stream_byte, newer_en_r)) begin
          emit        = 1'b1;
          o_tag_nxt   = in_stream_byte;
          o_known_nxt = 1'b0;
          o_last_nxt  = 1'b1;
        end else begin
          tag_nxt   = in_stream_byte;
          fnum_nxt  = 1'b0;
          rem_nxt   = {13'd0, cpep_pkg::field_size(in_stream_byte, 2'd0)};
          acc_nxt   = 32'd0;
          phase_nxt = cpep_pkg::PH_FIELD;
        end
      end
    endcase
    o_two_nxt = o_known_nxt &
                (o_tag_nxt == cpep_pkg::TAG_LONG || o_tag_nxt == cpep_pkg::TAG_DOUBLE);
  end

  // Parse state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cpep_pkg::PH_TAG;
      tag_r   <= 8'd0;
      fnum_r  <= 1'b0;
      rem_r   <= 16'd0;
      acc_r   <= 32'd0;
    end else if (in_accept) begin
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
      fnum_r  <= fnum_nxt;
      rem_r   <= rem_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newer_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      newer_en_r <= cfg_wr_data;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload, loaded only with a new result
  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      o_tag_r   <= o_tag_nxt;
      o_slot_r  <= o_slot_nxt;
      o_value_r <= o_value_nxt;
      o_known_r <= o_known_nxt;
      o_two_r   <= o_two_nxt;
      o_last_r  <= o_last_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_entry_tag       = o_tag_r;
  assign out_field_slot      = o_slot_r;
  assign out_field_value     = o_value_r;
  assign out_tag_known       = o_known_r;
  assign out_takes_two_slots = o_two_r;
  assign out_last_of_entry   = o_last_r;

  // Checks
  `CPEP_ASSERT_IMP(a_field_rem_nonzero, clk, rst_n,
    phase_r == cpep_pkg::PH_FIELD, rem_r != 16'd0)
  `CPEP_ASSERT_IMP(a_body_rem_nonzero, clk, rst_n,
    phase_r == cpep_pkg::PH_BODY, rem_r != 16'd0)
  `CPEP_ASSERT_IMP(a_unknown_shape, clk, rst_n, out_valid_r && !o_known_r,
    o_last_r && o_slot_r == cpep_pkg::SLOT_FIRST && o_value_r == 32'd0 && !o_two_r)
  `CPEP_ASSERT_IMP(a_two_slots_tag, clk, rst_n, out_valid_r && o_two_r,
    o_known_r && (o_tag_r == cpep_pkg::TAG_LONG || o_tag_r == cpep_pkg::TAG_DOUBLE))
  `CPEP_ASSERT_NXT(a_body_result, clk, rst_n,
    in_accept && phase_r == cpep_pkg::PH_BODY,
    out_valid_r && o_slot_r == cpep_pkg::SLOT_BODY)

endmodule

### tb/constant_pool_entry_parser_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for constant_pool_entry_parser_unit: drives byte requests,
// predicts every parsed field and compares each result. Depends on cpep_pkg.sv.

module constant_pool_entry_parser_unit_test;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 60;
  localparam int DRAIN_CYCLES  = 8;
  localparam int PHASE_BYTES   = 60;
  localparam int RANDOM_PHASES = 6;
  localparam int PRESSURE_PHASE = 2;
  localparam int MAX_REPORTS   = 40;

  localparam logic [7:0] KNOWN_TAGS [0:16] = '{
    cpep_pkg::TAG_UTF8, cpep_pkg::TAG_INTEGER, cpep_pkg::TAG_FLOAT,
    cpep_pkg::TAG_LONG, cpep_pkg::TAG_DOUBLE, cpep_pkg::TAG_CLASS,
    cpep_pkg::TAG_STRING, cpep_pkg::TAG_FIELDREF, cpep_pkg::TAG_METHODREF,
    cpep_pkg::TAG_IMETHODREF, cpep_pkg::TAG_NAMEANDTYPE, cpep_pkg::TAG_METHODHNDL,
    cpep_pkg::TAG_METHODTYPE, cpep_pkg::TAG_DYNAMIC, cpep_pkg::TAG_INVOKEDYN,
    cpep_pkg::TAG_MODULE, cpep_pkg::TAG_PACKAGE
  };

  typedef struct packed {
    logic [7:0]  entry_tag;
    logic [1:0]  field_slot;
    logic [31:0] field_value;
    logic        tag_known;
    logic        takes_two_slots;
    logic        last_of_entry;
  } field_result_t;

  // Byte count of field k of an entry; zero when the entry has no such field
  function automatic int layout_bytes(logic [7:0] t, int k);
    case (t)
      cpep_pkg::TAG_UTF8: return (k == 0) ? 2 : 0;
      cpep_pkg::TAG_INTEGER, cpep_pkg::TAG_FLOAT: return (k == 0) ? 4 : 0;
      cpep_pkg::TAG_LONG, cpep_pkg::TAG_DOUBLE: return (k <= 1) ? 4 : 0;
      cpep_pkg::TAG_CLASS, cpep_pkg::TAG_STRING, cpep_pkg::TAG_METHODTYPE,
      cpep_pkg::TAG_MODULE, cpep_pkg::TAG_PACKAGE:
        return (k == 0) ? 2 : 0;
      cpep_pkg::TAG_FIELDREF, cpep_pkg::TAG_METHODREF, cpep_pkg::TAG_IMETHODREF,
      cpep_pkg::TAG_NAMEANDTYPE, cpep_pkg::TAG_DYNAMIC, cpep_pkg::TAG_INVOKEDYN:
        return (k <= 1) ? 2 : 0;
      cpep_pkg::TAG_METHODHNDL: return (k == 0) ? 1 : ((k == 1) ? 2 : 0);
      default: return 0;
    endcase
  endfunction

  // Parse-state shadow plus the queue of fields still owed by the block
  class entry_scoreboard;
    cpep_pkg::phase_t phase;
    logic [7:0]    cur_tag;
    logic [1:0]    field_no;
    logic [15:0]   remaining;
    logic [31:0]   acc;
    logic          newer_en;
    field_result_t owed_fields[$];
    int            errors;

    function new();
      phase     = cpep_pkg::PH_TAG;
      cur_tag   = 8'd0;
      field_no  = 2'd0;
      remaining = 16'd0;
      acc       = 32'd0;
      newer_en  = 1'b1;
      errors    = 0;
    endfunction

    function void set_newer(logic v);
      newer_en = v;
    endfunction

    function bit recognizes(logic [7:0] t);
      if (t == cpep_pkg::TAG_DYNAMIC || t == cpep_pkg::TAG_MODULE ||
          t == cpep_pkg::TAG_PACKAGE) return newer_en;
      return layout_bytes(t, 0) != 0;
    endfunction

    function int pending();
      return owed_fields.size();
    endfunction

    function void owe(logic [7:0] t, logic [1:0] slot, logic [31:0] value,
                      logic known, logic last);
      field_result_t r;
      r.entry_tag       = t;
      r.field_slot      = slot;
      r.field_value     = value;
      r.tag_known       = known;
      r.takes_two_slots = known && (t == cpep_pkg::TAG_LONG || t == cpep_pkg::TAG_DOUBLE);
      r.last_of_entry   = last;
      owed_fields.push_back(r);
    endfunction

    // Advance the shadow parser by one accepted byte
    function void note_byte(logic [7:0] b);
      int nxt;
      case (phase)
        cpep_pkg::PH_FIELD: begin
          acc       = {acc[23:0], b};
          remaining = remaining - 16'd1;
          if (remaining == 16'd0) begin
            if (cur_tag == cpep_pkg::TAG_UTF8) begin
              // length result; an empty string ends the entry here
              owe(cur_tag, cpep_pkg::SLOT_FIRST, {16'd0, acc[15:0]}, 1'b1,
                  acc[15:0] == 16'd0);
              if (acc[15:0] == 16'd0) begin
                phase = cpep_pkg::PH_TAG;
              end else begin
                phase     = cpep_pkg::PH_BODY;
                remaining = acc[15:0];
              end
            end else begin
              nxt = layout_bytes(cur_tag, int'(field_no) + 1);
              owe(cur_tag, field_no, acc, 1'b1, nxt == 0);
              if (nxt == 0) begin
                phase = cpep_pkg::PH_TAG;
              end else begin
                field_no  = field_no + 2'd1;
                remaining = 16'(nxt);
                acc       = 32'd0;
              end
            end
          end
        end
        cpep_pkg::PH_BODY: begin
          remaining = remaining - 16'd1;
          owe(cur_tag, cpep_pkg::SLOT_BODY, {24'd0, b}, 1'b1, remaining == 16'd0);
          if (remaining == 16'd0) phase = cpep_pkg::PH_TAG;
        end
        default: begin
          phase = cpep_pkg::PH_TAG;
          if (!recognizes(b)) begin
            // unknown tag: skipped, only the tag byte is consumed
            owe(b, cpep_pkg::SLOT_FIRST, 32'd0, 1'b0, 1'b1);
          end else begin
            cur_tag   = b;
            field_no  = 2'd0;
            remaining = 16'(layout_bytes(b, 0));
            acc       = 32'd0;
            phase     = cpep_pkg::PH_FIELD;
          end
        end
      endcase
    endfunction

    function void report(string name, logic [31:0] want, logic [31:0] got);
      if (errors < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    endfunction

    function void check_result(field_result_t got);
      field_result_t want;
      if (owed_fields.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual tag %0h slot %0d value %0h",
                   $time, got.entry_tag, got.field_slot, got.field_value);
        errors++;
        return;
      end
      want = owed_fields.pop_front();
      if (got.entry_tag !== want.entry_tag)
        report("entry_tag", 32'(want.entry_tag), 32'(got.entry_tag));
      if (got.field_slot !== want.field_slot)
        report("field_slot", 32'(want.field_slot), 32'(got.field_slot));
      if (got.field_value !== want.field_value)
        report("field_value", want.field_value, got.field_value);
      if (got.tag_known !== want.tag_known)
        report("tag_known", 32'(want.tag_known), 32'(got.tag_known));
      if (got.takes_two_slots !== want.takes_two_slots)
        report("takes_two_slots", 32'(want.takes_two_slots), 32'(got.takes_two_slots));
      if (got.last_of_entry !== want.last_of_entry)
        report("last_of_entry", 32'(want.last_of_entry), 32'(got.last_of_entry));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_stream_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_entry_tag;
  logic [1:0]  out_field_slot;
  logic [31:0] out_field_value;
  logic        out_tag_known;
  logic        out_takes_two_slots;
  logic        out_last_of_entry;

  entry_scoreboard board = new();
  int unsigned     cycle_count = 0;
  int              bytes_sent = 0;
  bit              tx_idle_on = 1'b1;
  bit              rx_idle_on = 1'b1;
  bit              hold_request = 1'b0;

  constant_pool_entry_parser_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_stream_byte      (in_stream_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_entry_tag       (out_entry_tag),
    .out_field_slot      (out_field_slot),
    .out_field_value     (out_field_value),
    .out_tag_known       (out_tag_known),
    .out_takes_two_slots (out_takes_two_slots),
    .out_last_of_entry   (out_last_of_entry)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Every accepted result goes to the scoreboard
  always @(posedge clk) begin : result_monitor
    field_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_entry_tag, out_field_slot, out_field_value, out_tag_known,
             out_takes_two_slots, out_last_of_entry};
      board.check_result(got);
    end
  end

  function automatic logic [7:0] random_field_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sender gap; valid stays high when no gap is taken
  task automatic idle_gap();
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Offer one byte request and hold it until it is taken
  task automatic send_byte(input logic [7:0] b);
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    do @(posedge clk); while (in_stall);
    board.note_byte(b);
    bytes_sent++;
    idle_gap();
  endtask

  task automatic send_list(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Config change with the parser drained
  task automatic write_newer(input logic v);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_newer(v);
  endtask

  // One random entry: mostly well formed, some stray bytes and cut-short entries
  task automatic send_entry();
    logic [7:0] t;
    int         style;
    int         len;
    int         k;
    style = $urandom_range(0, 19);
    if (style == 0) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 9) == 0) t = 8'($urandom_range(0, 255));
    else t = KNOWN_TAGS[$urandom_range(0, 16)];
    send_byte(t);
    if (!board.recognizes(t)) return;
    if (style == 1) begin
      repeat ($urandom_range(0, 2)) send_byte(random_field_byte());
      return;
    end
    if (t == cpep_pkg::TAG_UTF8) begin
      len = ($urandom_range(0, 24) == 0) ? $urandom_range(200, 300) : $urandom_range(0, 6);
      send_byte(8'(len >> 8));
      send_byte(8'(len));
      repeat (len) send_byte(8'($urandom_range(0, 255)));
    end else begin
      for (k = 0; layout_bytes(t, k) != 0; k++)
        repeat (layout_bytes(t, k)) send_byte(random_field_byte());
    end
  endtask

  initial begin
    logic [7:0] stream[$];
    int         p;
    int         start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes as unknown tags, all-ones and mixed wide fields,
    // long entry, empty and short strings, a newer tag while enabled
    stream = '{8'h00, 8'hFF,
               cpep_pkg::TAG_INTEGER, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
               cpep_pkg::TAG_LONG, 8'h00, 8'h00, 8'h00, 8'h00,
               8'h80, 8'h00, 8'h00, 8'h01,
               cpep_pkg::TAG_UTF8, 8'h00, 8'h00,
               cpep_pkg::TAG_UTF8, 8'h00, 8'h02, 8'h00, 8'hFF,
               cpep_pkg::TAG_PACKAGE, 8'h12, 8'h34};
    send_list(stream);

    // Newer tags disabled: they become unknown; method handle layout
    write_newer(1'b0);
    stream = '{cpep_pkg::TAG_DYNAMIC, cpep_pkg::TAG_MODULE, cpep_pkg::TAG_PACKAGE,
               cpep_pkg::TAG_METHODHNDL, 8'h07, 8'h00, 8'h2A};
    send_list(stream);
    write_newer(1'b1);

    // Random phases; the pressure phase keeps offering while results are held
    for (p = 0; p < RANDOM_PHASES; p++) begin
      tx_idle_on = (p != RANDOM_PHASES - 1) && (p != PRESSURE_PHASE) &&
                   ($urandom_range(0, 3) != 0);
      rx_idle_on = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      if (p == PRESSURE_PHASE) hold_request = 1'b1;
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) send_entry();
      if (p < RANDOM_PHASES - 1)
        write_newer((p < 2) ? logic'(p == 1) : logic'($urandom_range(0, 1)));
    end

    // Drain
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
